/* sv/cia_pkg.sv */
`timescale 1ns / 1ps

package cia_pkg;

    // fixed field widths
    localparam int IDENT_W = 8;
    localparam int TAG_W   = 32;
    localparam int COUNT_W = 9;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register reset values
    localparam logic [IDENT_W-1:0] START_IDENT_RST  = 8'd64;
    localparam logic [IDENT_W-1:0] FIRST_USABLE_RST = 8'd1;
    localparam logic [IDENT_W-1:0] NULL_IDENT_RST   = 8'd0;

    // register indexes (word address paddr[3:2])
    typedef enum logic [1:0] {
        REG_START_IDENT  = 2'd0,
        REG_FIRST_USABLE = 2'd1,
        REG_NULL_IDENT   = 2'd2,
        REG_NONE         = 2'd3
    } t_reg_idx;

    // command codes
    typedef enum logic [1:0] {
        CMD_ALLOC      = 2'd0,
        CMD_LOOKUP     = 2'd1,
        CMD_FREE_ONE   = 2'd2,
        CMD_FREE_OWNER = 2'd3
    } t_cmd;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_LOOKUP_RD,
        ST_LOOKUP_RES,
        ST_FREE_ONE,
        ST_SWEEP,
        ST_SWEEP_DRAIN,
        ST_FINISH
    } t_state;

    // configuration register set
    typedef struct packed {
        logic [IDENT_W-1:0] start_ident;
        logic [IDENT_W-1:0] first_usable;
        logic [IDENT_W-1:0] null_ident;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic load;
        logic alloc_step;
        logic lookup_rd;
        logic lookup_done;
        logic free_one;
        logic sweep_rd;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        t_cmd in_cmd;
        logic alloc_done;
        logic sweep_last;
        logic out_free;
    } t_dp_sts;

endpackage

/* sv/cia_if.sv */
`timescale 1ns / 1ps

// request channel
interface cia_req_if import cia_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_cmd                 cmd;
    logic [TAG_W-1:0]     owner_tag;
    logic [IDENT_W-1:0]   ident_in;

    modport source (output valid, cmd, owner_tag, ident_in, input ready);
    modport sink   (input valid, cmd, owner_tag, ident_in, output ready);
endinterface

// response channel
interface cia_rsp_if import cia_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [IDENT_W-1:0]   ident_out;
    logic [TAG_W-1:0]     owner_out;
    logic                 found;
    logic [COUNT_W-1:0]   removed_count;

    modport source (output valid, ident_out, owner_out, found, removed_count, input ready);
    modport sink   (input valid, ident_out, owner_out, found, removed_count, output ready);
endinterface

/* sv/command_ident_allocator.sv */
`timescale 1ns / 1ps

// Command identifier allocator. Holds a held flag per identifier in flip-flops,
// cleared at reset, and an owner tag memory with one write and one registered
// read port that needs no clearing, since a tag is only used while its
// identifier is held. One command is worked at a time; the next beat is taken
// as soon as the controller returns to idle, even while the previous result
// still waits in the output register. Allocate examines one held flag per
// cycle and claims the first free candidate or gives up after at most 256
// candidates; lookup goes through the registered memory read; free by owner
// makes one memory read per entry.
// Registers sit at byte addresses 0 (start ident), 4 (first usable) and 8
// (null ident) and should only be written while no command is in progress.
module command_ident_allocator import cia_pkg::*; #(
    parameter int IDENT_SLOTS = 256,
    parameter int TAG_BITS    = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    cia_req_if.sink            i_req,
    cia_rsp_if.source          o_rsp
);

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // configuration registers
    cia_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // controller
    cia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // datapath
    cia_dp #(
        .IDENT_SLOTS (IDENT_SLOTS),
        .TAG_BITS    (TAG_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

/* sv/cia_regs.sv */
`timescale 1ns / 1ps

module cia_regs import cia_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;

    // register writes, low byte only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_ident  <= START_IDENT_RST;
            r_cfg.first_usable <= FIRST_USABLE_RST;
            r_cfg.null_ident   <= NULL_IDENT_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_START_IDENT:  r_cfg.start_ident  <= pwdata[IDENT_W-1:0];
                REG_FIRST_USABLE: r_cfg.first_usable <= pwdata[IDENT_W-1:0];
                REG_NULL_IDENT:   r_cfg.null_ident   <= pwdata[IDENT_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_START_IDENT:  prdata = PDATA_W'(r_cfg.start_ident);
            REG_FIRST_USABLE: prdata = PDATA_W'(r_cfg.first_usable);
            REG_NULL_IDENT:   prdata = PDATA_W'(r_cfg.null_ident);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/cia_ctrl.sv */
`timescale 1ns / 1ps

module cia_ctrl import cia_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_sts.in_valid) begin
                    case (i_sts.in_cmd)
                        CMD_ALLOC:    n_state = ST_ALLOC;
                        CMD_LOOKUP:   n_state = ST_LOOKUP_RD;
                        CMD_FREE_ONE: n_state = ST_FREE_ONE;
                        default:      n_state = ST_SWEEP;
                    endcase
                end
            end
            ST_ALLOC: begin
                if (i_sts.alloc_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_LOOKUP_RD:   n_state = ST_LOOKUP_RES;
            ST_LOOKUP_RES:  n_state = ST_FINISH;
            ST_FREE_ONE:    n_state = ST_FINISH;
            ST_SWEEP: begin
                if (i_sts.sweep_last) begin
                    n_state = ST_SWEEP_DRAIN;
                end
            end
            ST_SWEEP_DRAIN: n_state = ST_FINISH;
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:        n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd             = '0;
        o_cmd.in_ready    = (r_state == ST_IDLE);
        o_cmd.load        = (r_state == ST_IDLE) && i_sts.in_valid;
        o_cmd.alloc_step  = (r_state == ST_ALLOC);
        o_cmd.lookup_rd   = (r_state == ST_LOOKUP_RD);
        o_cmd.lookup_done = (r_state == ST_LOOKUP_RES);
        o_cmd.free_one    = (r_state == ST_FREE_ONE);
        o_cmd.sweep_rd    = (r_state == ST_SWEEP);
        o_cmd.out_load    = (r_state == ST_FINISH) && i_sts.out_free;
    end

endmodule

/* sv/cia_dp.sv */
`timescale 1ns / 1ps

module cia_dp import cia_pkg::*; #(
    parameter int IDENT_SLOTS = 256,
    parameter int TAG_BITS    = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  t_dp_cmd         i_cmd,
    output t_dp_sts         o_sts,
    cia_req_if.sink         i_req,
    cia_rsp_if.source       o_rsp
);

    localparam int IDX_W   = $clog2(IDENT_SLOTS);
    localparam int STORE_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam logic [COUNT_W-1:0] SCAN_MAX = COUNT_W'(256);
    localparam logic [COUNT_W-1:0] SLOTS_C  = COUNT_W'(IDENT_SLOTS);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(IDENT_SLOTS - 1);

    // raise a candidate to the lowest usable ident
    function automatic logic [IDENT_W-1:0] f_raise(
        input logic [IDENT_W-1:0] v,
        input logic [IDENT_W-1:0] floor_v
    );
        return (v < floor_v) ? floor_v : v;
    endfunction

    // held flags and owner store
    logic [IDENT_SLOTS-1:0] r_held;
    logic [STORE_W-1:0]     mem_owner [IDENT_SLOTS];

    // item registers
    logic [STORE_W-1:0]     r_tag;
    logic [IDENT_W-1:0]     r_ident;
    logic [IDENT_W-1:0]     r_cand;
    logic [COUNT_W-1:0]     r_steps;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_rd_idx;
    logic                   r_rd_vld;
    logic [STORE_W-1:0]     r_rd_data;

    // result and output registers
    logic [IDENT_W-1:0]     r_res_ident;
    logic [TAG_W-1:0]       r_res_owner;
    logic                   r_res_found;
    logic [COUNT_W-1:0]     r_res_count;
    logic                   r_out_valid;
    logic [IDENT_W-1:0]     r_out_ident;
    logic [TAG_W-1:0]       r_out_owner;
    logic                   r_out_found;
    logic [COUNT_W-1:0]     r_out_count;

    logic [IDX_W-1:0]       w_cand_idx;
    logic [IDX_W-1:0]       w_id_idx;
    logic [IDX_W-1:0]       w_rd_addr;
    logic                   w_fail;
    logic                   w_claim;
    logic                   w_id_hit;
    logic                   w_sweep_hit;
    logic                   w_out_free;
    logic [IDENT_W-1:0]     w_first_cand;
    logic [IDENT_W-1:0]     w_next_cand;

    assign w_cand_idx   = r_cand[IDX_W-1:0];
    assign w_id_idx     = r_ident[IDX_W-1:0];
    assign w_rd_addr    = i_cmd.sweep_rd ? r_idx : w_id_idx;
    assign w_first_cand = f_raise(i_cfg.start_ident + 8'd1, i_cfg.first_usable);
    assign w_next_cand  = f_raise(r_cand + 8'd1, i_cfg.first_usable);

    // one allocation candidate per cycle
    assign w_fail  = (r_steps == SCAN_MAX) || (r_cand == i_cfg.start_ident);
    assign w_claim = !w_fail && ({1'b0, r_cand} < SLOTS_C) && !r_held[w_cand_idx];

    // ident lookup and sweep compare
    assign w_id_hit    = ({1'b0, r_ident} < SLOTS_C) && r_held[w_id_idx];
    assign w_sweep_hit = r_rd_vld && r_held[r_rd_idx] && (r_rd_data == r_tag);

    assign w_out_free = !r_out_valid || o_rsp.ready;

    // status to controller
    always_comb begin
        o_sts.in_valid   = i_req.valid;
        o_sts.in_cmd     = i_req.cmd;
        o_sts.alloc_done = w_fail || w_claim;
        o_sts.sweep_last = (r_idx == LAST_IDX);
        o_sts.out_free   = w_out_free;
    end

    assign i_req.ready = i_cmd.in_ready;

    // held flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else begin
            if (i_cmd.alloc_step && w_claim) begin
                r_held[w_cand_idx] <= 1'b1;
            end
            if (i_cmd.free_one && w_id_hit) begin
                r_held[w_id_idx] <= 1'b0;
            end
            if (w_sweep_hit) begin
                r_held[r_rd_idx] <= 1'b0;
            end
        end
    end

    // owner store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_step && w_claim) begin
            mem_owner[w_cand_idx] <= r_tag;
        end
        if (i_cmd.lookup_rd || i_cmd.sweep_rd) begin
            r_rd_data <= mem_owner[w_rd_addr];
        end
    end

    // sweep read pipeline flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.sweep_rd;
        end
    end

    // item capture, scan and sweep counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag   <= i_req.owner_tag[STORE_W-1:0];
            r_ident <= i_req.ident_in;
            r_cand  <= w_first_cand;
            r_steps <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.alloc_step) begin
                r_cand  <= w_next_cand;
                r_steps <= r_steps + 9'd1;
            end
            if (i_cmd.sweep_rd) begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (i_cmd.sweep_rd) begin
            r_rd_idx <= r_idx;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            case (i_req.cmd)
                CMD_ALLOC:      r_res_ident <= i_cfg.null_ident;
                CMD_FREE_OWNER: r_res_ident <= '0;
                default:        r_res_ident <= i_req.ident_in;
            endcase
            r_res_owner <= '0;
            r_res_found <= 1'b0;
            r_res_count <= '0;
        end else begin
            if (i_cmd.alloc_step && w_claim) begin
                r_res_ident <= r_cand;
                r_res_found <= 1'b1;
            end
            if (i_cmd.lookup_done && w_id_hit) begin
                r_res_owner <= TAG_W'(r_rd_data);
                r_res_found <= 1'b1;
            end
            if (i_cmd.free_one && w_id_hit) begin
                r_res_count <= 9'd1;
            end
            if (w_sweep_hit) begin
                r_res_count <= r_res_count + 9'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ident <= r_res_ident;
            r_out_owner <= r_res_owner;
            r_out_found <= r_res_found;
            r_out_count <= r_res_count;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.ident_out     = r_out_ident;
    assign o_rsp.owner_out     = r_out_owner;
    assign o_rsp.found         = r_out_found;
    assign o_rsp.removed_count = r_out_count;

endmodule

/* sim/ident_table_checker.sv */
`timescale 1ns / 1ps

// watches the register port and both channels, keeps its own copy of the
// identifier table and compares every result beat with the oldest prediction
module ident_table_checker import cia_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    cia_req_if                 req_mon,
    cia_rsp_if                 rsp_mon,
    output int                 o_fail_count,
    output int                 o_waiting
);

    localparam int IDENT_SPAN = 256;

    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic [TAG_W-1:0]   owner;
        logic               found;
        logic [COUNT_W-1:0] removed;
    } t_ident_result;

    // mirrored table and registers
    logic               held_map  [IDENT_SPAN];
    logic [TAG_W-1:0]   tag_store [IDENT_SPAN];
    t_cfg               cfg;
    t_ident_result      pending_results [$];

    // works one command on the mirrored table and gives the result it causes
    function automatic t_ident_result apply_command(t_cmd cmd, logic [TAG_W-1:0] tag,
                                                    logic [IDENT_W-1:0] ident);
        t_ident_result res;
        logic [IDENT_W-1:0] cand;
        logic done;
        int steps;
        res = '0;
        case (cmd)
            CMD_ALLOC: begin
                res.ident = cfg.null_ident;
                cand = cfg.start_ident + 8'd1;
                if (cand < cfg.first_usable) cand = cfg.first_usable;
                done = 1'b0;
                steps = 0;
                // scan upward, wrapping, until start is met or the span is used up
                while (!done && steps < IDENT_SPAN && cand != cfg.start_ident) begin
                    if (!held_map[cand]) begin
                        held_map[cand] = 1'b1;
                        tag_store[cand] = tag;
                        res.ident = cand;
                        res.found = 1'b1;
                        done = 1'b1;
                    end else begin
                        cand = cand + 8'd1;
                        if (cand < cfg.first_usable) cand = cfg.first_usable;
                        steps++;
                    end
                end
            end
            CMD_LOOKUP: begin
                res.ident = ident;
                if (held_map[ident]) begin
                    res.owner = tag_store[ident];
                    res.found = 1'b1;
                end
            end
            CMD_FREE_ONE: begin
                res.ident = ident;
                if (held_map[ident]) begin
                    held_map[ident] = 1'b0;
                    res.removed = COUNT_W'(1);
                end
            end
            default: begin
                // release every identifier held by this tag
                for (int i = 0; i < IDENT_SPAN; i++) begin
                    if (held_map[i] && tag_store[i] == tag) begin
                        held_map[i] = 1'b0;
                        res.removed = res.removed + 1'b1;
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic check_field(string name, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_ident_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < IDENT_SPAN; i++) held_map[i] = 1'b0;
            cfg = '{START_IDENT_RST, FIRST_USABLE_RST, NULL_IDENT_RST};
            pending_results.delete();
        end else begin
            // result beat against the oldest prediction
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with no command outstanding: ident %0h",
                           rsp_mon.ident_out);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("ident_out", TAG_W'(want.ident), TAG_W'(rsp_mon.ident_out));
                    check_field("owner_out", want.owner, rsp_mon.owner_out);
                    check_field("found", TAG_W'(want.found), TAG_W'(rsp_mon.found));
                    check_field("removed_count", TAG_W'(want.removed),
                                TAG_W'(rsp_mon.removed_count));
                end
            end
            // command beat
            if (req_mon.valid && req_mon.ready)
                pending_results.push_back(apply_command(req_mon.cmd, req_mon.owner_tag,
                                                        req_mon.ident_in));
            // register write, low byte only
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_START_IDENT:  cfg.start_ident  = pwdata[IDENT_W-1:0];
                    REG_FIRST_USABLE: cfg.first_usable = pwdata[IDENT_W-1:0];
                    REG_NULL_IDENT:   cfg.null_ident   = pwdata[IDENT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_waiting = pending_results.size();
    end

endmodule

/* sim/tb_command_ident_allocator.sv */
`timescale 1ns / 1ps

module tb_command_ident_allocator;
    import cia_pkg::*;

    localparam int  CLK_PERIOD   = 10;
    localparam int  LONG_HOLD    = 80;
    localparam int  SETTLE       = 4;
    localparam int  END_WAIT     = 300;
    localparam real RUN_LIMIT_NS = 8_000_000.0;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 results_waiting;

    // shared between the command source and the result sink
    bit                 hold_pending;
    bit                 no_idle;

    // what the source last wrote, used to aim identifiers at the live range
    logic [IDENT_W-1:0] cur_start;
    logic [IDENT_W-1:0] cur_first;
    logic [TAG_W-1:0]   tag_pool [4];

    cia_req_if req_if ();
    cia_rsp_if rsp_if ();

    command_ident_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    ident_table_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .req_mon      (req_if),
        .rsp_mon      (rsp_if),
        .o_fail_count (fail_count),
        .o_waiting    (results_waiting)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // mostly short gaps, some none, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 50);
    endfunction

    // offers one command beat and returns at the negedge after it is taken
    task automatic send_cmd(t_cmd cmd, logic [TAG_W-1:0] tag, logic [IDENT_W-1:0] ident);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.cmd       <= cmd;
        req_if.owner_tag <= tag;
        req_if.ident_in  <= ident;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        t_cmd               cmd;
        logic [TAG_W-1:0]   tag;
        logic [IDENT_W-1:0] ident;
        logic [IDENT_W-1:0] offs;
        int                 roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)      cmd = CMD_ALLOC;
        else if (roll < 60) cmd = CMD_LOOKUP;
        else if (roll < 85) cmd = CMD_FREE_ONE;
        else                cmd = CMD_FREE_OWNER;
        // a small pool of owners so that sweeps find something to release
        if ($urandom_range(0, 9) < 8) tag = tag_pool[$urandom_range(0, 3)];
        else                          tag = $urandom;
        roll = $urandom_range(0, 9);
        if (roll < 5) begin
            offs = IDENT_W'($urandom_range(1, 32));
            ident = cur_start + offs;
        end else if (roll < 8) begin
            offs = IDENT_W'($urandom_range(0, 15));
            ident = cur_first + offs;
        end else begin
            ident = IDENT_W'($urandom);
        end
        send_cmd(cmd, tag, ident);
    endtask

    // lets every outstanding result come back before the block is touched
    task automatic drain_block();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (results_waiting != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // setup then access; upper data bits are noise the block must ignore
    task automatic reg_write(t_reg_idx idx, logic [IDENT_W-1:0] value);
        logic [PDATA_W-1:0] word;
        word = $urandom;
        word[IDENT_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [IDENT_W-1:0] start, logic [IDENT_W-1:0] first,
                              logic [IDENT_W-1:0] null_val);
        drain_block();
        reg_write(REG_START_IDENT, start);
        reg_write(REG_FIRST_USABLE, first);
        reg_write(REG_NULL_IDENT, null_val);
        cur_start = start;
        cur_first = first;
    endtask

    task automatic run_random(int count);
        repeat (count) send_random();
    endtask

    // result sink: runs of ready with random gaps, one long hold on request
    initial begin : result_sink
        int gap;
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_pending) begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_pending = 1'b0;
            end else begin
                gap = no_idle ? 0 : pick_gap();
                if (gap > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    initial begin : stimulus
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_if.valid     = 1'b0;
        req_if.cmd       = CMD_ALLOC;
        req_if.owner_tag = '0;
        req_if.ident_in  = '0;
        hold_pending     = 1'b0;
        no_idle          = 1'b0;
        cur_start        = START_IDENT_RST;
        cur_first        = FIRST_USABLE_RST;
        tag_pool[0]      = '0;
        tag_pool[1]      = '1;
        tag_pool[2]      = $urandom;
        tag_pool[3]      = $urandom;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings, tag and ident extremes, every command
        send_cmd(CMD_ALLOC, 32'h0000_0000, 8'h00);
        send_cmd(CMD_ALLOC, 32'hFFFF_FFFF, 8'hFF);
        send_cmd(CMD_LOOKUP, 32'h0, 8'd65);
        send_cmd(CMD_LOOKUP, 32'h0, 8'd66);
        send_cmd(CMD_LOOKUP, 32'h0, 8'h00);
        send_cmd(CMD_LOOKUP, 32'h0, 8'hFF);
        send_cmd(CMD_FREE_ONE, 32'h0, 8'd65);
        send_cmd(CMD_FREE_ONE, 32'h0, 8'd65);
        send_cmd(CMD_ALLOC, 32'hA5A5_A5A5, 8'h0);
        send_cmd(CMD_ALLOC, 32'hA5A5_A5A5, 8'h0);
        send_cmd(CMD_LOOKUP, 32'h0, 8'd67);
        send_cmd(CMD_FREE_OWNER, 32'hA5A5_A5A5, 8'h0);
        send_cmd(CMD_FREE_OWNER, 32'h1234_5678, 8'h0);
        send_cmd(CMD_FREE_ONE, 32'h0, 8'h00);
        send_cmd(CMD_FREE_ONE, 32'h0, 8'hFF);
        send_cmd(CMD_FREE_OWNER, 32'hFFFF_FFFF, 8'h0);

        // start equals first usable at the top: nothing can be handed out
        set_config(8'hFF, 8'hFF, 8'hC3);
        send_cmd(CMD_ALLOC, 32'h5A5A_5A5A, 8'h0);
        // start below first usable: scan never meets start; the first claims 255, the second gives up
        set_config(8'h00, 8'hFF, 8'h3C);
        send_cmd(CMD_ALLOC, 32'h5555_5555, 8'h0);
        send_cmd(CMD_ALLOC, 32'h5555_5555, 8'h0);
        send_cmd(CMD_LOOKUP, 32'h0, 8'hFF);
        send_cmd(CMD_FREE_OWNER, 32'h5555_5555, 8'h0);
        // first usable of zero lets ident 0 through
        set_config(8'hFF, 8'h00, 8'h00);
        send_cmd(CMD_ALLOC, 32'hAAAA_AAAA, 8'h0);
        send_cmd(CMD_LOOKUP, 32'h0, 8'h00);
        send_cmd(CMD_FREE_ONE, 32'h0, 8'h00);

        // random phases over a spread of settings
        set_config(8'd64, 8'd1, 8'd0);
        hold_pending = 1'b1;
        run_random(70);
        set_config(8'd200, 8'd0, 8'hFF);
        run_random(60);
        set_config(8'hFF, 8'd250, 8'h5A);
        run_random(60);
        set_config(8'd10, 8'd240, 8'h80);
        run_random(60);
        set_config(IDENT_W'($urandom), IDENT_W'($urandom), IDENT_W'($urandom));
        no_idle = 1'b1;
        run_random(60);
        drain_block();
        no_idle = 1'b0;
        set_config(8'd0, 8'd1, 8'd0);
        run_random(60);
        set_config(IDENT_W'($urandom), IDENT_W'($urandom_range(0, 40)), IDENT_W'($urandom));
        run_random(60);

        // let the last results return and catch any stray beat
        drain_block();
        repeat (END_WAIT) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
